FILE: rtl/shd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_pkg
// Shared types and the fixed code tree of the static Huffman decoder.
// ----------------------------------------------------------------------------
package shd_pkg;

   localparam int NodeW  = 8;
   localparam int ChildW = 10;

   localparam logic signed [ChildW-1:0] FLUSH_LEAF = -10'sd256;

   typedef logic signed [ChildW-1:0] child_type;

   // per node: [1] taken on a 1 bit, [0] taken on a 0 bit
   // positive = inner node, zero or negative = leaf with negated symbol, except -256 = flush leaf
   localparam logic signed [1:0][ChildW-1:0] CODE_TREE [256] = '{
      '{1, 2}, '{3, 4}, '{5, 0}, '{6, 7},
      '{8, 9}, '{10, 11}, '{12, 13}, '{-256, 14},
      '{15, 16}, '{17, 18}, '{19, 20}, '{21, 22},
      '{-1, 23}, '{24, 25}, '{26, 27}, '{28, 29},
      '{30, 31}, '{32, 33}, '{34, 35}, '{36, 37},
      '{38, 39}, '{40, -64}, '{41, 42}, '{43, 44},
      '{-6, 45}, '{46, 47}, '{48, 49}, '{50, 51},
      '{-119, 52}, '{-32, 53}, '{54, -14}, '{55, -5},
      '{56, 57}, '{58, 59}, '{60, -2}, '{61, 62},
      '{63, 64}, '{65, 66}, '{67, 68}, '{69, 70},
      '{71, 72}, '{-51, 73}, '{74, 75}, '{76, 77},
      '{-101, -111}, '{-4, -97}, '{78, 79}, '{-110, 80},
      '{81, -116}, '{82, 83}, '{84, -255}, '{85, 86},
      '{87, 88}, '{89, 90}, '{-15, -10}, '{91, 92},
      '{-21, 93}, '{-117, 94}, '{95, 96}, '{97, 98},
      '{99, 100}, '{-114, 101}, '{-105, 102}, '{-26, 103},
      '{104, 105}, '{106, 107}, '{108, 109}, '{110, 111},
      '{112, -3}, '{113, -7}, '{114, -131}, '{115, -144},
      '{116, 117}, '{-20, 118}, '{119, 120}, '{121, 122},
      '{123, 124}, '{125, 126}, '{127, 128}, '{129, -100},
      '{130, -8}, '{131, 132}, '{133, 134}, '{-120, 135},
      '{136, -31}, '{137, 138}, '{-109, -234}, '{139, 140},
      '{141, 142}, '{143, 144}, '{-112, 145}, '{-19, 146},
      '{147, 148}, '{149, -66}, '{150, -145}, '{-13, -65},
      '{151, 152}, '{153, 154}, '{-30, 155}, '{156, 157},
      '{-99, 158}, '{159, 160}, '{161, 162}, '{-23, 163},
      '{-29, 164}, '{-11, 165}, '{166, -115}, '{167, 168},
      '{169, 170}, '{-16, 171}, '{-34, 172}, '{173, -132},
      '{174, -108}, '{175, -22}, '{176, -9}, '{177, -84},
      '{-17, -37}, '{-28, 178}, '{179, 180}, '{181, 182},
      '{183, 184}, '{185, 186}, '{187, -104}, '{188, -78},
      '{189, -61}, '{-79, -178}, '{-59, -134}, '{190, -25},
      '{-83, -18}, '{191, -57}, '{-67, 192}, '{-98, 193},
      '{-12, -68}, '{194, 195}, '{-55, -128}, '{-24, -50},
      '{-70, 196}, '{-94, -33}, '{197, -129}, '{-74, 198},
      '{-82, 199}, '{-56, -87}, '{-44, 200}, '{-248, 201},
      '{-163, -81}, '{-52, -123}, '{202, -113}, '{-48, -41},
      '{-122, -40}, '{203, -90}, '{-54, 204}, '{-86, -192},
      '{205, 206}, '{207, -130}, '{-53, 208}, '{-133, -45},
      '{209, 210}, '{211, -91}, '{212, 213}, '{-106, -88},
      '{214, 215}, '{216, 217}, '{218, -49}, '{219, 220},
      '{221, 222}, '{223, 224}, '{225, 226}, '{227, -102},
      '{-160, 228}, '{-46, 229}, '{-127, 230}, '{-103, 231},
      '{232, 233}, '{-60, 234}, '{235, -76}, '{236, -121},
      '{237, -73}, '{-149, 238}, '{239, -107}, '{-35, 240},
      '{-71, -27}, '{-69, 241}, '{-89, -77}, '{-62, -118},
      '{-75, -85}, '{-72, -58}, '{-63, -80}, '{242, -42},
      '{-150, -157}, '{-139, -236}, '{-126, -243}, '{-142, -214},
      '{-138, -206}, '{-240, -146}, '{-204, -147}, '{-152, -201},
      '{-227, -207}, '{-154, -209}, '{-153, -254}, '{-176, -156},
      '{-165, -210}, '{-172, -185}, '{-195, -170}, '{-232, -211},
      '{-219, -239}, '{-200, -177}, '{-175, -212}, '{-244, -143},
      '{-246, -171}, '{-203, -221}, '{-202, -181}, '{-173, -250},
      '{-184, -164}, '{-193, -218}, '{-199, -220}, '{-190, -249},
      '{-230, -217}, '{-169, -216}, '{-191, -197}, '{-47, 243},
      '{244, 245}, '{246, 247}, '{-148, -159}, '{248, 249},
      '{-92, -93}, '{-96, -225}, '{-151, -95}, '{250, 251},
      '{-241, 252}, '{-161, -36}, '{253, 254}, '{-135, -39},
      '{-187, -124}, '{255, -251}, '{-162, -238}, '{-242, -38},
      '{-43, -125}, '{-215, -253}, '{-140, -208}, '{-137, -235},
      '{-158, -237}, '{-136, -205}, '{-155, -141}, '{-228, -229},
      '{-213, -168}, '{-224, -194}, '{-196, -226}, '{-183, -233},
      '{-231, -167}, '{-174, -189}, '{-252, -166}, '{-198, -222},
      '{-188, -179}, '{-223, -182}, '{-180, -186}, '{-245, -247}
   };

   typedef struct packed {
      logic load;
      logic restart;
      logic step;
      logic final_push;
   } cmd_type;

   typedef struct packed {
      logic blocked;
      logic flush;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/shd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_ctrl
// Sequencer: loads an item, walks up to eight bits, drains the held symbol.
// ----------------------------------------------------------------------------
module shd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_mode,
   output logic             req_stall,
   input  shd_pkg::sts_type sts,
   output shd_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {IDLE, WALK, FINISH} state_type;

   state_type  state_ff;
   logic [2:0] bit_cnt_ff;
   logic       stall_ff;

   always_comb begin
      cmd.load       = (state_ff == IDLE) && req_valid && !req_mode;
      cmd.restart    = (state_ff == IDLE) && req_valid && req_mode;
      cmd.step       = (state_ff == WALK) && !sts.blocked;
      cmd.final_push = (state_ff == FINISH) && sts.pend_valid && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         bit_cnt_ff <= '0;
         stall_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (cmd.load) begin
                  state_ff   <= WALK;
                  bit_cnt_ff <= '0;
                  stall_ff   <= 1'b1;
               end
            end
            WALK: begin
               if (cmd.step) begin
                  bit_cnt_ff <= bit_cnt_ff + 3'd1;
                  if (sts.flush || (bit_cnt_ff == 3'd7)) begin
                     state_ff <= FINISH;
                  end
               end
            end
            FINISH: begin
               if (!sts.pend_valid || sts.out_free) begin
                  state_ff <= IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = stall_ff;

endmodule

FILE: rtl/shd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_datapath
// Tree position, bit shifter, held symbol and output register.
// ----------------------------------------------------------------------------
module shd_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_data_byte,
   input  shd_pkg::cmd_type cmd,
   output shd_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_in_run
);

   logic [shd_pkg::NodeW-1:0] pos_ff;
   logic [7:0]                shift_ff;
   logic [7:0]                pend_ff;
   logic                      pend_valid_ff;
   logic                      out_valid_ff;
   logic [7:0]                out_byte_ff;
   logic                      out_last_ff;

   shd_pkg::child_type child;
   logic               is_leaf;
   logic               is_flush;
   logic               is_sym;
   logic               out_free;
   logic               push_mid;
   logic [7:0]         sym;

   always_comb begin
      child    = shd_pkg::CODE_TREE[pos_ff][shift_ff[7]];
      is_leaf  = (child <= 0);
      is_flush = (child == shd_pkg::FLUSH_LEAF);
      is_sym   = is_leaf && !is_flush;
      sym      = 8'(-child);
      out_free = !out_valid_ff || !rsp_stall;
      push_mid = cmd.step && is_sym && pend_valid_ff;
      sts.blocked    = is_sym && pend_valid_ff && !out_free;
      sts.flush      = is_flush;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.restart) begin
            pos_ff <= '0;
         end else if (cmd.step) begin
            pos_ff <= is_leaf ? '0 : child[shd_pkg::NodeW-1:0];
         end
         if (cmd.step && is_sym) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.final_push) begin
            pend_valid_ff <= 1'b0;
         end
         if (push_mid || cmd.final_push) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         shift_ff <= req_data_byte;
      end else if (cmd.step) begin
         shift_ff <= {shift_ff[6:0], 1'b0};
      end
      if (cmd.step && is_sym) begin
         pend_ff <= sym;
      end
      if (push_mid || cmd.final_push) begin
         out_byte_ff <= pend_ff;
         out_last_ff <= cmd.final_push;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_in_run = out_last_ff;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (push_mid || cmd.final_push) |-> out_free)
      else $error("output overwritten");
   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !pend_valid_ff)
      else $error("held symbol left from previous item");
   a_restart_root: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> (pos_ff == '0))
      else $error("restart did not return to root");

endmodule

FILE: rtl/static_huffman_decoder_unit.sv
`timescale 1ns / 1ps
// each data item is accepted, walked through up to eight tree steps and then
// finished before the next is taken; a flush leaf ends the byte early, and
// output stalls pause the walk when the held symbol cannot move on
// reset: synchronous, returns the walk to the root and drops any pending item
// ----------------------------------------------------------------------------
// static_huffman_decoder_unit
// Static Huffman decoder over a fixed 256-node code tree, msb first.
// ----------------------------------------------------------------------------
module static_huffman_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_in_run
);

   shd_pkg::cmd_type cmd;
   shd_pkg::sts_type sts;

   shd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   shd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule
